// ===== design/rje_pkg.sv =====
// Shared constants, types and helpers for the RTT jitter estimator.
// No dependencies; imported by the top level and by the port checker.
package rje_pkg;

    // Time base: microseconds with FRAC_BITS fraction bits kept in state
    localparam int TIME_BITS  = 24;
    localparam int FRAC_BITS  = 8;

    // Field widths
    localparam int SAMPLE_W   = 24;
    localparam int TIME_W     = 24;
    localparam int GAIN_W     = 9;
    localparam int MULT_W     = 4;
    localparam int SAFETY_W   = 12;
    localparam int GAIN_FRAC  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Stream payload widths
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 2 * TIME_W;
    localparam int OUT_USER_W = 3;

    // Non-negative samples only, so the estimate never needs the sign bit
    localparam int STATE_W    = SAMPLE_W - 1 + FRAC_BITS;
    localparam int UPD_W      = STATE_W + GAIN_W;
    localparam int TO_SUM_W   = STATE_W + MULT_W;
    localparam int IP_SUM_W   = STATE_W + SAFETY_W + 1;
    localparam int TO_RAW_W   = TO_SUM_W - FRAC_BITS;
    localparam int IP_RAW_W   = IP_SUM_W - FRAC_BITS - GAIN_FRAC;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC);

    // Saturation limit of both result times
    localparam logic [TIME_W-1:0] TIME_LIMIT = (TIME_BITS < TIME_W)
        ? TIME_W'((64'd1 << TIME_BITS) - 64'd1)
        : {TIME_W{1'b1}};

    // Register reset values
    localparam logic [TIME_W-1:0]   MIN_TIMEOUT_RST = TIME_W'(200000);
    localparam logic [TIME_W-1:0]   MAX_TIMEOUT_RST = {TIME_W{1'b1}};
    localparam logic [GAIN_W-1:0]   ALPHA_RST       = GAIN_W'(32);
    localparam logic [GAIN_W-1:0]   BETA_RST        = GAIN_W'(64);
    localparam logic [MULT_W-1:0]   MULT_RST        = MULT_W'(4);
    localparam logic [SAFETY_W-1:0] SAFETY_RST      = SAFETY_W'(256);

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_SEEDED   = 2'd0,
        ST_UPDATED  = 2'd1,
        ST_REJECTED = 2'd2,
        ST_CLEARED  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_TIMEOUT = 3'd0,
        REG_MAX_TIMEOUT = 3'd1,
        REG_ALPHA       = 3'd2,
        REG_BETA        = 3'd3,
        REG_VAR_MULT    = 3'd4,
        REG_SAFETY      = 3'd5
    } cfg_reg_t;

    // Gains above one count as one
    function automatic logic [GAIN_W-1:0] gain_sat(input logic [GAIN_W-1:0] g);
        gain_sat = (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

endpackage

// ===== design/rtt_jitter_estimator_top.sv =====
// RTT jitter estimator top level: smoothed RTT / variation update and
// timeout / interpolation delay results. Depends on rje_pkg.
//
// Usage:
//   Input stream (s_*): one transfer per item. s_tuser holds the opcode
//   (sample or clear), s_tdata the signed round-trip sample in microseconds.
//   Output stream (m_*): exactly one result transfer per input transfer, in
//   order: status and has_estimate in m_tuser, timeout and interpolation
//   delay in m_tdata.
//   Config port (cfg_*): register index plus data, always ready; write only
//   while no item is in flight.
// Pipeline and throughput:
//   A result passes the input register, estimate update (gain multiplies),
//   result multiplies and clamp into the output register before m_tvalid.
//   One item per cycle is sustained while m_tready stays high.
// Reset: rst_n clears the estimate, empties the pipeline and reloads the
//   config registers with their defaults.
// Stall:
//   Each stage has its own valid bit; while m_tready is low, empty stages
//   keep filling, and s_tready drops only once all four stages are full.
module rtt_jitter_estimator_top
    import rje_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [23:0] sample_us
    input  logic [IN_USER_W-1:0]  s_tuser,   // [0] opcode

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [23:0] timeout_us, [47:24] interp_delay_us
    output logic [OUT_USER_W-1:0] m_tuser,   // [1:0] status, [2] has_estimate

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ---------------- configuration registers ----------------
    logic [TIME_W-1:0]   min_timeout_reg;
    logic [TIME_W-1:0]   max_timeout_reg;
    logic [GAIN_W-1:0]   alpha_reg;
    logic [GAIN_W-1:0]   beta_reg;
    logic [MULT_W-1:0]   var_mult_reg;
    logic [SAFETY_W-1:0] safety_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_timeout_reg <= MIN_TIMEOUT_RST;
            max_timeout_reg <= MAX_TIMEOUT_RST;
            alpha_reg       <= ALPHA_RST;
            beta_reg        <= BETA_RST;
            var_mult_reg    <= MULT_RST;
            safety_reg      <= SAFETY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MIN_TIMEOUT: min_timeout_reg <= cfg_data[TIME_W-1:0];
                REG_MAX_TIMEOUT: max_timeout_reg <= cfg_data[TIME_W-1:0];
                REG_ALPHA:       alpha_reg       <= cfg_data[GAIN_W-1:0];
                REG_BETA:        beta_reg        <= cfg_data[GAIN_W-1:0];
                REG_VAR_MULT:    var_mult_reg    <= cfg_data[MULT_W-1:0];
                REG_SAFETY:      safety_reg      <= cfg_data[SAFETY_W-1:0];
                default:         ; // unmapped index, write dropped
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic in_valid_reg;
    logic upd_valid_reg;
    logic res_valid_reg;
    logic out_valid_reg;

    logic out_ready;
    logic res_ready;
    logic upd_ready;
    logic in_ready;

    assign out_ready = !out_valid_reg || m_tready;
    assign res_ready = !res_valid_reg || out_ready;
    assign upd_ready = !upd_valid_reg || res_ready;
    assign in_ready  = !in_valid_reg  || upd_ready;
    assign s_tready  = in_ready;

    // ---------------- stage 1: input register ----------------
    logic                       op_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_tvalid)
        begin
            op_reg     <= s_tuser[0];
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
    end

    // ---------------- stage 2: estimate update ----------------
    logic [STATE_W-1:0] srtt_reg;
    logic [STATE_W-1:0] rttvar_reg;
    logic               est_valid_reg;

    logic [STATE_W-1:0] srtt_next;
    logic [STATE_W-1:0] rttvar_next;
    logic               est_valid_next;
    status_t            status_next;

    logic [STATE_W-1:0] sample_fx;
    logic [STATE_W-1:0] err;
    logic [GAIN_W-1:0]  alpha_eff;
    logic [GAIN_W-1:0]  beta_eff;
    logic [UPD_W-1:0]   srtt_sum;
    logic [UPD_W-1:0]   rttvar_sum;

    always_comb
    begin
        sample_fx = STATE_W'(sample_reg[SAMPLE_W-2:0]) << FRAC_BITS;
        err       = (srtt_reg >= sample_fx) ? (srtt_reg - sample_fx)
                                            : (sample_fx - srtt_reg);
        alpha_eff = gain_sat(alpha_reg);
        beta_eff  = gain_sat(beta_reg);
        // Variation uses the old srtt; both blends truncate
        rttvar_sum = UPD_W'(GAIN_ONE - beta_eff) * UPD_W'(rttvar_reg)
                   + UPD_W'(beta_eff) * UPD_W'(err);
        srtt_sum   = UPD_W'(GAIN_ONE - alpha_eff) * UPD_W'(srtt_reg)
                   + UPD_W'(alpha_eff) * UPD_W'(sample_fx);

        srtt_next      = srtt_reg;
        rttvar_next    = rttvar_reg;
        est_valid_next = est_valid_reg;
        status_next    = ST_REJECTED;
        case (opcode_t'(op_reg))
            OP_CLEAR:
            begin
                srtt_next      = '0;
                rttvar_next    = '0;
                est_valid_next = 1'b0;
                status_next    = ST_CLEARED;
            end
            OP_SAMPLE:
            begin
                if (sample_reg[SAMPLE_W-1])
                begin
                    status_next = ST_REJECTED;
                end
                else if (!est_valid_reg)
                begin
                    srtt_next      = sample_fx;
                    rttvar_next    = sample_fx >> 1;
                    est_valid_next = 1'b1;
                    status_next    = ST_SEEDED;
                end
                else
                begin
                    srtt_next   = srtt_sum[GAIN_FRAC +: STATE_W];
                    rttvar_next = rttvar_sum[GAIN_FRAC +: STATE_W];
                    status_next = ST_UPDATED;
                end
            end
            default:
            begin
                status_next = ST_REJECTED;
            end
        endcase
    end

    // Snapshot of the post-item estimate travels with the item
    logic [STATE_W-1:0] upd_srtt_reg;
    logic [STATE_W-1:0] upd_rttvar_reg;
    logic               upd_est_reg;
    status_t            upd_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_valid_reg <= 1'b0;
            srtt_reg      <= '0;
            rttvar_reg    <= '0;
            est_valid_reg <= 1'b0;
        end
        else if (upd_ready)
        begin
            upd_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                srtt_reg      <= srtt_next;
                rttvar_reg    <= rttvar_next;
                est_valid_reg <= est_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_ready && in_valid_reg)
        begin
            upd_srtt_reg   <= srtt_next;
            upd_rttvar_reg <= rttvar_next;
            upd_est_reg    <= est_valid_next;
            upd_status_reg <= status_next;
        end
    end

    // ---------------- stage 3: result products ----------------
    logic [TO_SUM_W-1:0] to_sum;
    logic [IP_SUM_W-1:0] ip_sum;

    always_comb
    begin
        to_sum = TO_SUM_W'(upd_srtt_reg)
               + TO_SUM_W'(var_mult_reg) * TO_SUM_W'(upd_rttvar_reg);
        // srtt/2 brought to the Q(FRAC+8) scale of safety*var
        ip_sum = (IP_SUM_W'(upd_srtt_reg) << (GAIN_FRAC - 1))
               + IP_SUM_W'(safety_reg) * IP_SUM_W'(upd_rttvar_reg);
    end

    logic [TO_RAW_W-1:0] res_to_reg;
    logic [IP_RAW_W-1:0] res_ip_reg;
    logic                res_est_reg;
    status_t             res_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            res_valid_reg <= upd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && upd_valid_reg)
        begin
            res_to_reg     <= to_sum[FRAC_BITS +: TO_RAW_W];
            res_ip_reg     <= ip_sum[(FRAC_BITS + GAIN_FRAC) +: IP_RAW_W];
            res_est_reg    <= upd_est_reg;
            res_status_reg <= upd_status_reg;
        end
    end

    // ---------------- stage 4: clamp into output register ----------------
    logic [TO_RAW_W-1:0] to_floor;
    logic [TO_RAW_W-1:0] to_ceil;
    logic [TIME_W-1:0]   timeout_next;
    logic [TIME_W-1:0]   interp_next;

    always_comb
    begin
        // floor first, then ceiling, so max wins when min > max
        to_floor = (res_to_reg < TO_RAW_W'(min_timeout_reg))
                 ? TO_RAW_W'(min_timeout_reg) : res_to_reg;
        to_ceil  = (to_floor > TO_RAW_W'(max_timeout_reg))
                 ? TO_RAW_W'(max_timeout_reg) : to_floor;
        if (!res_est_reg)
        begin
            timeout_next = min_timeout_reg;
            interp_next  = '0;
        end
        else
        begin
            timeout_next = (to_ceil > TO_RAW_W'(TIME_LIMIT))
                         ? TIME_LIMIT : to_ceil[TIME_W-1:0];
            interp_next  = (res_ip_reg > IP_RAW_W'(TIME_LIMIT))
                         ? TIME_LIMIT : res_ip_reg[TIME_W-1:0];
        end
    end

    logic [TIME_W-1:0] out_timeout_reg;
    logic [TIME_W-1:0] out_interp_reg;
    logic              out_est_reg;
    status_t           out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= res_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && res_valid_reg)
        begin
            out_timeout_reg <= timeout_next;
            out_interp_reg  <= interp_next;
            out_est_reg     <= res_est_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_interp_reg, out_timeout_reg};
    assign m_tuser  = {out_est_reg, out_status_reg};

endmodule

// ===== design/rje_checker.sv =====
// Port-level checker for the RTT jitter estimator, bound to the top level.
// Depends on rje_pkg for status codes and payload widths.
module rje_checker
    import rje_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // seeding or updating always leaves an estimate
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == ST_SEEDED || m_tuser[1:0] == ST_UPDATED)
        |-> m_tuser[2])
    else $error("sample accepted but no estimate flagged");

    // clear drops the estimate
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == ST_CLEARED |-> !m_tuser[2])
    else $error("estimate still flagged after clear");

    // no estimate: no interpolation delay, and no blend could have happened
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[2]
        |-> m_tdata[OUT_DATA_W-1:TIME_W] == '0 && m_tuser[1:0] != ST_UPDATED)
    else $error("result without estimate carries estimate data");

endmodule

bind rtt_jitter_estimator_top rje_checker u_rje_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for rtt_jitter_estimator_top: directed and random sample/clear
// transfers, checked against an in-bench model of the smoothed RTT and variation update.
// Depends on rje_pkg and the RTL top level only.
module tb_top;
    import rje_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 10;
    localparam int ITEMS_PER_PH = 120;
    localparam int IDLE_PCT     = 17;
    localparam int CALM_PHASE   = 5;   // no idling on either side in this phase

    typedef struct packed {
        opcode_t             op;
        logic [SAMPLE_W-1:0] sample;
    } rtt_item_t;

    typedef struct packed {
        status_t           status;
        logic [TIME_W-1:0] timeout;
        logic [TIME_W-1:0] interp;
        logic              has_est;
    } rto_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    rtt_jitter_estimator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bench copy of the estimator registers
    logic [TIME_W-1:0]   min_to    = MIN_TIMEOUT_RST;
    logic [TIME_W-1:0]   max_to    = MAX_TIMEOUT_RST;
    logic [GAIN_W-1:0]   alpha_q   = ALPHA_RST;
    logic [GAIN_W-1:0]   beta_q    = BETA_RST;
    logic [MULT_W-1:0]   var_mult  = MULT_RST;
    logic [SAFETY_W-1:0] safety_q  = SAFETY_RST;

    // Bench copy of the estimate, kept wide so no product can wrap
    logic [63:0] srtt_fx   = '0;
    logic [63:0] rttvar_fx = '0;
    logic        est_valid = 1'b0;

    rtt_item_t   sample_queue[$];
    rto_result_t rto_forecast[$];

    int  queued_cnt = 0;
    int  got_cnt    = 0;
    int  fail_cnt   = 0;
    int  cycles     = 0;
    bit  idle_on    = 1'b1;
    bit  in_took    = 1'b0;

    // Applies one item to the bench estimate and returns the result it produces
    function automatic rto_result_t estimate_update(input rtt_item_t it);
        rto_result_t r;
        logic [63:0] s, a, b, err, v;
        if (it.op == OP_CLEAR)
        begin
            srtt_fx   = '0;
            rttvar_fx = '0;
            est_valid = 1'b0;
            r.status  = ST_CLEARED;
        end
        else if (it.sample[SAMPLE_W-1])
        begin
            r.status = ST_REJECTED;
        end
        else
        begin
            s = 64'(it.sample) << FRAC_BITS;
            if (!est_valid)
            begin
                srtt_fx   = s;
                rttvar_fx = s >> 1;
                est_valid = 1'b1;
                r.status  = ST_SEEDED;
            end
            else
            begin
                // gains above one act as one
                a   = (alpha_q > 9'd256) ? 64'd256 : 64'(alpha_q);
                b   = (beta_q > 9'd256) ? 64'd256 : 64'(beta_q);
                err = (srtt_fx >= s) ? srtt_fx - s : s - srtt_fx;
                // variation uses the old srtt, so it goes first
                rttvar_fx = ((64'd256 - b) * rttvar_fx + b * err) >> 8;
                srtt_fx   = ((64'd256 - a) * srtt_fx + a * s) >> 8;
                r.status  = ST_UPDATED;
            end
        end

        if (!est_valid)
        begin
            r.timeout = min_to;
            r.interp  = '0;
        end
        else
        begin
            // floor first, then ceiling: max wins when min > max
            v = (srtt_fx + 64'(var_mult) * rttvar_fx) >> FRAC_BITS;
            if (v < 64'(min_to))
                v = 64'(min_to);
            if (v > 64'(max_to))
                v = 64'(max_to);
            if (v > 64'(TIME_LIMIT))
                v = 64'(TIME_LIMIT);
            r.timeout = v[TIME_W-1:0];
            v = ((srtt_fx << 7) + 64'(safety_q) * rttvar_fx) >> (FRAC_BITS + 8);
            if (v > 64'(TIME_LIMIT))
                v = 64'(TIME_LIMIT);
            r.interp = v[TIME_W-1:0];
        end
        r.has_est = est_valid;
        return r;
    endfunction

    // Input side: a new transfer is offered at the falling edge once the last one went through
    always @(negedge clk)
    begin
        rtt_item_t nx;
        if (rst_n)
        begin
            if (!s_tvalid || in_took)
            begin
                if (sample_queue.size() != 0 &&
                    !(idle_on && $urandom_range(99) < IDLE_PCT))
                begin
                    nx = sample_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nx.sample;
                    s_tuser  <= nx.op;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Accepted input transfers feed the bench estimate
    always @(posedge clk)
    begin
        rtt_item_t it;
        in_took = rst_n && s_tvalid && s_tready;
        if (in_took)
        begin
            it.op     = opcode_t'(s_tuser[0]);
            it.sample = s_tdata[SAMPLE_W-1:0];
            rto_forecast.push_back(estimate_update(it));
        end
    end

    // Result side: each transfer is checked against the oldest forecast
    always @(posedge clk)
    begin
        rto_result_t ex;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_cnt++;
            if (rto_forecast.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: unexpected result transfer tdata=%h tuser=%h",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                ex = rto_forecast.pop_front();
                if (m_tuser[1:0] != ex.status)
                begin
                    fail_cnt++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, ex.status, m_tuser[1:0]);
                end
                if (m_tuser[2] != ex.has_est)
                begin
                    fail_cnt++;
                    $display("%0t: has_estimate expected %0d actual %0d",
                             $time, ex.has_est, m_tuser[2]);
                end
                if (m_tdata[TIME_W-1:0] != ex.timeout)
                begin
                    fail_cnt++;
                    $display("%0t: timeout_us expected %0d actual %0d",
                             $time, ex.timeout, m_tdata[TIME_W-1:0]);
                end
                if (m_tdata[2*TIME_W-1:TIME_W] != ex.interp)
                begin
                    fail_cnt++;
                    $display("%0t: interp_delay_us expected %0d actual %0d",
                             $time, ex.interp, m_tdata[2*TIME_W-1:TIME_W]);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_item(input opcode_t op, input logic [SAMPLE_W-1:0] sample);
        rtt_item_t it;
        it.op     = op;
        it.sample = sample;
        sample_queue.push_back(it);
        queued_cnt++;
    endtask

    // Mostly valid samples of mixed magnitude, with some rejects and clears
    task automatic add_random_item();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            add_item(OP_CLEAR, SAMPLE_W'($urandom));
        else if (r < 12)
            add_item(OP_SAMPLE, {1'b1, 23'($urandom)});
        else if (r < 22)
            add_item(OP_SAMPLE, SAMPLE_W'($urandom_range(0, 15)));
        else if (r < 55)
            add_item(OP_SAMPLE, SAMPLE_W'($urandom_range(0, 24'h7FFFFF)));
        else
            add_item(OP_SAMPLE, SAMPLE_W'($urandom_range(0, 400000)));
    endtask

    // One register write; valid stays up across back-to-back writes
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MIN_TIMEOUT: min_to   = val[TIME_W-1:0];
            REG_MAX_TIMEOUT: max_to   = val[TIME_W-1:0];
            REG_ALPHA:       alpha_q  = val[GAIN_W-1:0];
            REG_BETA:        beta_q   = val[GAIN_W-1:0];
            REG_VAR_MULT:    var_mult = val[MULT_W-1:0];
            REG_SAFETY:      safety_q = val[SAFETY_W-1:0];
            default: ;
        endcase
    endtask

    // Fixed settings first (extremes, then the reset defaults), then random settings
    task automatic load_settings(input int ph);
        logic [CFG_DATA_W-1:0] v[6];
        case (ph)
            0: v = '{24'd0, 24'hFFFFFF, 24'd256, 24'd256, 24'd15, 24'd4095};
            1: v = '{24'hFFFFFF, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};      // min above max
            2: v = '{24'd1000, 24'd5000000, 24'd511, 24'd300, 24'd1, 24'd2048};
            3: v = '{24'd200000, 24'hFFFFFF, 24'd32, 24'd64, 24'd4, 24'd256};
            default:
            begin
                v[0] = CFG_DATA_W'($urandom_range(0, 300000));
                v[1] = CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
                v[2] = CFG_DATA_W'($urandom_range(0, 511));
                v[3] = CFG_DATA_W'($urandom_range(0, 511));
                v[4] = CFG_DATA_W'($urandom_range(0, 15));
                v[5] = CFG_DATA_W'($urandom_range(0, 4095));
            end
        endcase
        write_reg(REG_MIN_TIMEOUT, v[0]);
        write_reg(REG_MAX_TIMEOUT, v[1]);
        write_reg(REG_ALPHA,       v[2]);
        write_reg(REG_BETA,        v[3]);
        write_reg(REG_VAR_MULT,    v[4]);
        write_reg(REG_SAFETY,      v[5]);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (got_cnt != queued_cnt)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed part, reset settings
        add_item(OP_SAMPLE, 24'hFFFFFF);     // reject with no estimate
        add_item(OP_CLEAR,  24'd0);          // clear with no estimate
        add_item(OP_SAMPLE, 24'd0);          // zero seeds a zero estimate
        add_item(OP_SAMPLE, 24'd100000);
        add_item(OP_SAMPLE, 24'h7FFFFF);     // largest sample
        add_item(OP_SAMPLE, 24'h800000);     // most negative, estimate held
        add_item(OP_CLEAR,  24'hFFFFFF);
        add_item(OP_SAMPLE, 24'h7FFFFF);     // seed at the top, timeout saturates
        add_item(OP_SAMPLE, 24'd0);          // largest error
        add_item(OP_SAMPLE, 24'd1);
        add_item(OP_SAMPLE, 24'd2);
        add_item(OP_SAMPLE, 24'h555555);
        add_item(OP_SAMPLE, 24'h2AAAAA);
        add_item(OP_SAMPLE, 24'hAAAAAA);     // negative
        add_item(OP_CLEAR,  24'h555555);
        add_item(OP_SAMPLE, 24'd3);          // small seed, timeout at the floor
        add_item(OP_SAMPLE, 24'd250000);
        add_item(OP_SAMPLE, 24'd180000);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            load_settings(ph);
            idle_on = (ph != CALM_PHASE);
            add_item(OP_CLEAR, 24'd0);
            for (int i = 0; i < ITEMS_PER_PH; i++)
                add_random_item();
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (fail_cnt == 0 && rto_forecast.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
